/* rtl/bgi_pkg.sv */
package bgi_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DEGEN     = 2'd1,
    ST_BAD_COUNT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_LINE = 2'd1,
    MODE_AREA = 2'd2
  } mode_t;

  typedef struct packed {
    logic    valid;
    mode_t   mode;
    status_t status;
  } ctl_t;

endpackage

/* rtl/bgi_prep.sv */
module bgi_prep #(
  parameter int CW = 32,
  parameter int VW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic [2:0]           point_count,
  input  logic signed [CW-1:0] lo_x,
  input  logic signed [CW-1:0] lo_y,
  input  logic signed [CW-1:0] hi_x,
  input  logic signed [CW-1:0] hi_y,
  input  logic signed [VW-1:0] val_lo_lo,
  input  logic signed [VW-1:0] val_lo_hi,
  input  logic signed [VW-1:0] val_hi_lo,
  input  logic signed [VW-1:0] val_hi_hi,
  input  logic signed [CW-1:0] req_x,
  input  logic signed [CW-1:0] req_y,
  output bgi_pkg::ctl_t        ctl_o,
  output logic signed [CW:0]   dxh_o,
  output logic signed [CW:0]   dxl_o,
  output logic signed [CW:0]   dyh_o,
  output logic signed [CW:0]   dyl_o,
  output logic signed [CW:0]   wx_o,
  output logic signed [CW:0]   wy_o,
  output logic signed [CW:0]   span_o,
  output logic signed [CW:0]   off_o,
  output logic signed [VW:0]   dval_o,
  output logic signed [VW-1:0] vll_o,
  output logic signed [VW-1:0] vlh_o,
  output logic signed [VW-1:0] vhl_o,
  output logic signed [VW-1:0] vhh_o
);
  import bgi_pkg::*;

  localparam int DC = CW + 1;
  localparam int DV = VW + 1;
  localparam logic [2:0] CNT_ONE  = 3'd1;
  localparam logic [2:0] CNT_TWO  = 3'd2;
  localparam logic [2:0] CNT_FOUR = 3'd4;

  ctl_t                 ctl_nxt, ctl_r;
  logic signed [DC-1:0] dxh_nxt, dxl_nxt, dyh_nxt, dyl_nxt, wx_nxt, wy_nxt;
  logic signed [DC-1:0] span_nxt, off_nxt;
  logic signed [DC-1:0] dxh_r, dxl_r, dyh_r, dyl_r, wx_r, wy_r, span_r, off_r;
  logic signed [DV-1:0] dval_nxt, dval_r;
  logic signed [VW-1:0] vll_r, vlh_r, vhl_r, vhh_r;
  logic                 along_x;

  always_comb begin
    dxh_nxt  = DC'(hi_x) - DC'(req_x);
    dxl_nxt  = DC'(req_x) - DC'(lo_x);
    dyh_nxt  = DC'(hi_y) - DC'(req_y);
    dyl_nxt  = DC'(req_y) - DC'(lo_y);
    wx_nxt   = DC'(hi_x) - DC'(lo_x);
    wy_nxt   = DC'(hi_y) - DC'(lo_y);
    along_x  = (lo_x != hi_x);
    span_nxt = along_x ? wx_nxt : wy_nxt;
    off_nxt  = along_x ? dxl_nxt : dyl_nxt;
    dval_nxt = DV'(val_hi_hi) - DV'(val_lo_lo);
    ctl_nxt.valid = acc;
    case (point_count)
      CNT_ONE: begin
        ctl_nxt.mode   = MODE_PASS;
        ctl_nxt.status = ST_OK;
      end
      CNT_TWO: begin
        ctl_nxt.mode   = MODE_LINE;
        ctl_nxt.status = (lo_x == hi_x && lo_y == hi_y) ? ST_DEGEN : ST_OK;
      end
      CNT_FOUR: begin
        ctl_nxt.mode   = MODE_AREA;
        ctl_nxt.status = (hi_x == lo_x || hi_y == lo_y) ? ST_DEGEN : ST_OK;
      end
      default: begin
        ctl_nxt.mode   = MODE_PASS;
        ctl_nxt.status = ST_BAD_COUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dxh_r  <= dxh_nxt;
    dxl_r  <= dxl_nxt;
    dyh_r  <= dyh_nxt;
    dyl_r  <= dyl_nxt;
    wx_r   <= wx_nxt;
    wy_r   <= wy_nxt;
    span_r <= span_nxt;
    off_r  <= off_nxt;
    dval_r <= dval_nxt;
    vll_r  <= val_lo_lo;
    vlh_r  <= val_lo_hi;
    vhl_r  <= val_hi_lo;
    vhh_r  <= val_hi_hi;
  end

  assign ctl_o  = ctl_r;
  assign dxh_o  = dxh_r;
  assign dxl_o  = dxl_r;
  assign dyh_o  = dyh_r;
  assign dyl_o  = dyl_r;
  assign wx_o   = wx_r;
  assign wy_o   = wy_r;
  assign span_o = span_r;
  assign off_o  = off_r;
  assign dval_o = dval_r;
  assign vll_o  = vll_r;
  assign vlh_o  = vlh_r;
  assign vhl_o  = vhl_r;
  assign vhh_o  = vhh_r;

endmodule

/* rtl/bgi_mult.sv */
module bgi_mult #(
  parameter int CW = 32,
  parameter int VW = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bgi_pkg::ctl_t               ctl_i,
  input  logic signed [CW:0]          dxh_i,
  input  logic signed [CW:0]          dxl_i,
  input  logic signed [CW:0]          dyh_i,
  input  logic signed [CW:0]          dyl_i,
  input  logic signed [CW:0]          wx_i,
  input  logic signed [CW:0]          wy_i,
  input  logic signed [CW:0]          span_i,
  input  logic signed [CW:0]          off_i,
  input  logic signed [VW:0]          dval_i,
  input  logic signed [VW-1:0]        vll_i,
  input  logic signed [VW-1:0]        vlh_i,
  input  logic signed [VW-1:0]        vhl_i,
  input  logic signed [VW-1:0]        vhh_i,
  output bgi_pkg::ctl_t               ctl_o,
  output logic signed [VW+2*CW+3:0]   num_o,
  output logic signed [2*CW+1:0]      den_o,
  output logic signed [VW-1:0]        vll_o
);
  import bgi_pkg::*;

  localparam int DC = CW + 1;
  localparam int PW = 2 * CW + 2;
  localparam int H  = CW + 1;
  localparam int LW = VW + H + 1;
  localparam int HW = VW + H;
  localparam int LP = VW + CW + 2;
  localparam int NW = VW + 2 * CW + 4;

  // Stage a: coordinate products, cell area and the two-node numerator.
  ctl_t                 ctl_a_r;
  logic signed [PW-1:0] pw_nxt [4];
  logic signed [PW-1:0] pw_a_r [4];
  logic signed [VW-1:0] v_a_r  [4];
  logic signed [PW-1:0] area_a_r;
  logic signed [LP-1:0] lnum_a_r;
  logic signed [DC-1:0] lden_a_r;

  assign pw_nxt[0] = PW'(dxh_i * dyh_i);
  assign pw_nxt[1] = PW'(dxl_i * dyh_i);
  assign pw_nxt[2] = PW'(dxh_i * dyl_i);
  assign pw_nxt[3] = PW'(dxl_i * dyl_i);

  // Stage b: value times product, split into two partial products.
  ctl_t                 ctl_b_r;
  logic signed [LW-1:0] lo_nxt [4];
  logic signed [HW-1:0] hi_nxt [4];
  logic signed [LW-1:0] lo_b_r [4];
  logic signed [HW-1:0] hi_b_r [4];
  logic signed [PW-1:0] den_b_nxt, den_b_r;
  logic signed [LP-1:0] lnum_b_r;
  logic signed [VW-1:0] vll_b_r;

  // Stage c: recombined terms.
  ctl_t                 ctl_c_r;
  logic signed [NW-1:0] term_nxt [4];
  logic signed [NW-1:0] term_c_r [4];
  logic signed [PW-1:0] den_c_r;
  logic signed [LP-1:0] lnum_c_r;
  logic signed [VW-1:0] vll_c_r;

  // Stage d: pair sums.
  ctl_t                 ctl_d_r;
  logic signed [NW-1:0] s01_d_r, s23_d_r;
  logic signed [PW-1:0] den_d_r;
  logic signed [LP-1:0] lnum_d_r;
  logic signed [VW-1:0] vll_d_r;

  // Stage e: numerator for the division.
  ctl_t                 ctl_e_r;
  logic signed [NW-1:0] num_e_nxt, num_e_r;
  logic signed [PW-1:0] den_e_r;
  logic signed [VW-1:0] vll_e_r;

  for (genvar k = 0; k < 4; k++) begin : g_term
    assign lo_nxt[k]   = LW'(v_a_r[k] * $signed({1'b0, pw_a_r[k][H-1:0]}));
    assign hi_nxt[k]   = HW'(v_a_r[k] * $signed(pw_a_r[k][PW-1:H]));
    assign term_nxt[k] = (NW'(hi_b_r[k]) <<< H) + NW'(lo_b_r[k]);
  end

  assign den_b_nxt = (ctl_a_r.mode == MODE_LINE) ? PW'(lden_a_r) : area_a_r;
  assign num_e_nxt = (ctl_d_r.mode == MODE_LINE) ? NW'(lnum_d_r) : s01_d_r + s23_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      ctl_c_r <= '0;
      ctl_d_r <= '0;
      ctl_e_r <= '0;
    end else begin
      ctl_a_r <= ctl_i;
      ctl_b_r <= ctl_a_r;
      ctl_c_r <= ctl_b_r;
      ctl_d_r <= ctl_c_r;
      ctl_e_r <= ctl_d_r;
    end
  end

  always_ff @(posedge clk) begin
    pw_a_r   <= pw_nxt;
    v_a_r[0] <= vll_i;
    v_a_r[1] <= vhl_i;
    v_a_r[2] <= vlh_i;
    v_a_r[3] <= vhh_i;
    area_a_r <= PW'(wx_i * wy_i);
    lnum_a_r <= LP'(dval_i * off_i);
    lden_a_r <= span_i;

    lo_b_r   <= lo_nxt;
    hi_b_r   <= hi_nxt;
    den_b_r  <= den_b_nxt;
    lnum_b_r <= lnum_a_r;
    vll_b_r  <= v_a_r[0];

    term_c_r <= term_nxt;
    den_c_r  <= den_b_r;
    lnum_c_r <= lnum_b_r;
    vll_c_r  <= vll_b_r;

    s01_d_r  <= term_c_r[0] + term_c_r[1];
    s23_d_r  <= term_c_r[2] + term_c_r[3];
    den_d_r  <= den_c_r;
    lnum_d_r <= lnum_c_r;
    vll_d_r  <= vll_c_r;

    num_e_r  <= num_e_nxt;
    den_e_r  <= den_d_r;
    vll_e_r  <= vll_d_r;
  end

  assign ctl_o = ctl_e_r;
  assign num_o = num_e_r;
  assign den_o = den_e_r;
  assign vll_o = vll_e_r;

endmodule

/* rtl/bgi_div.sv */
module bgi_div #(
  parameter int CW = 32,
  parameter int VW = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bgi_pkg::ctl_t             ctl_i,
  input  logic signed [VW+2*CW+3:0] num_i,
  input  logic signed [2*CW+1:0]    den_i,
  input  logic signed [VW-1:0]      vll_i,
  output bgi_pkg::ctl_t             ctl_o,
  output logic [VW:0]               quo_o,
  output logic                      neg_o,
  output logic                      ovf_o,
  output logic signed [VW-1:0]      vll_o
);
  import bgi_pkg::*;

  localparam int NW = VW + 2 * CW + 4;
  localparam int DW = 2 * CW + 2;
  localparam int K  = VW + 1;
  localparam int TW = NW - K;

  // Magnitude stage.
  ctl_t                 ctl_a_r;
  logic [NW-1:0]        nm_nxt, nm_a_r;
  logic [DW-1:0]        dm_nxt, dm_a_r;
  logic                 neg_a_r;
  logic signed [VW-1:0] vll_a_r;

  assign nm_nxt = num_i[NW-1] ? $unsigned(-num_i) : $unsigned(num_i);
  assign dm_nxt = den_i[DW-1] ? $unsigned(-den_i) : $unsigned(den_i);

  // Overflow check, then one quotient bit per stage.
  ctl_t                 ctl_nxt [0:K];
  ctl_t                 ctl_r   [0:K];
  logic [K-1:0]         quo_nxt [0:K];
  logic [K-1:0]         quo_r   [0:K];
  logic                 neg_nxt [0:K];
  logic                 neg_r   [0:K];
  logic                 ovf_nxt [0:K];
  logic                 ovf_r   [0:K];
  logic signed [VW-1:0] vll_nxt [0:K];
  logic signed [VW-1:0] vll_r   [0:K];
  logic [DW-1:0]        rem_nxt [0:K-1];
  logic [DW-1:0]        rem_r   [0:K-1];
  logic [DW-1:0]        dm_s_nxt [0:K-1];
  logic [DW-1:0]        dm_s_r   [0:K-1];
  logic [K-1:0]         nlo_nxt [0:K-1];
  logic [K-1:0]         nlo_r   [0:K-1];

  // The quotient overflows the result range when the high part of the
  // numerator is not below the divisor; the remainder then starts from it.
  assign ctl_nxt[0]  = ctl_a_r;
  assign quo_nxt[0]  = '0;
  assign neg_nxt[0]  = neg_a_r;
  assign ovf_nxt[0]  = nm_a_r[NW-1:K] >= TW'(dm_a_r);
  assign vll_nxt[0]  = vll_a_r;
  assign rem_nxt[0]  = nm_a_r[K+DW-1:K];
  assign dm_s_nxt[0] = dm_a_r;
  assign nlo_nxt[0]  = nm_a_r[K-1:0];

  for (genvar j = 0; j < K; j++) begin : g_step
    logic [DW:0] trial;
    logic        fits;

    assign trial          = {rem_r[j], nlo_r[j][K-1-j]};
    assign fits           = trial >= {1'b0, dm_s_r[j]};
    assign quo_nxt[j+1]   = {quo_r[j][K-2:0], fits};
    assign ctl_nxt[j+1]   = ctl_r[j];
    assign neg_nxt[j+1]   = neg_r[j];
    assign ovf_nxt[j+1]   = ovf_r[j];
    assign vll_nxt[j+1]   = vll_r[j];

    if (j < K - 1) begin : g_carry
      assign rem_nxt[j+1]  = fits ? DW'(trial - {1'b0, dm_s_r[j]}) : trial[DW-1:0];
      assign dm_s_nxt[j+1] = dm_s_r[j];
      assign nlo_nxt[j+1]  = nlo_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_r   <= '{default: '0};
    end else begin
      ctl_a_r <= ctl_i;
      ctl_r   <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nm_a_r  <= nm_nxt;
    dm_a_r  <= dm_nxt;
    neg_a_r <= num_i[NW-1] ^ den_i[DW-1];
    vll_a_r <= vll_i;
    quo_r   <= quo_nxt;
    neg_r   <= neg_nxt;
    ovf_r   <= ovf_nxt;
    vll_r   <= vll_nxt;
    rem_r   <= rem_nxt;
    dm_s_r  <= dm_s_nxt;
    nlo_r   <= nlo_nxt;
  end

  assign ctl_o = ctl_r[K];
  assign quo_o = quo_r[K];
  assign neg_o = neg_r[K];
  assign ovf_o = ovf_r[K];
  assign vll_o = vll_r[K];

endmodule

/* rtl/bilinear_grid_interp_unit.sv */
// Bilinear interpolation on one grid cell, Q16.16 fixed point.
//
// An item is taken at a rising edge where start is high and busy is low.
// busy is always low: the block is a fixed pipeline and takes a new item in
// every cycle. Each item carries a node count, the cell corners, up to four
// node values and a request position.
//
// Every item gives exactly one result, shown on out_interp_value and
// out_status for a single cycle while out_valid is high. Results leave in
// the order the items came in. Each item passes the prep register, the
// product and sum stages, the magnitude stage and overflow stage of the
// restoring divider, which then resolves one quotient bit per stage, and
// the output register.
//
// The receiver has no means to hold results off; none is needed, as the
// pipeline never stops. A synchronous reset (rst_n low) clears the valid bits
// of every stage, so items in flight are dropped and no result appears.
module bilinear_grid_interp_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_point_count,
  input  logic signed [COORD_WIDTH-1:0] in_lo_x,
  input  logic signed [COORD_WIDTH-1:0] in_lo_y,
  input  logic signed [COORD_WIDTH-1:0] in_hi_x,
  input  logic signed [COORD_WIDTH-1:0] in_hi_y,
  input  logic signed [VALUE_WIDTH-1:0] in_val_lo_lo,
  input  logic signed [VALUE_WIDTH-1:0] in_val_lo_hi,
  input  logic signed [VALUE_WIDTH-1:0] in_val_hi_lo,
  input  logic signed [VALUE_WIDTH-1:0] in_val_hi_hi,
  input  logic signed [COORD_WIDTH-1:0] in_req_x,
  input  logic signed [COORD_WIDTH-1:0] in_req_y,
  output logic                          out_valid,
  output logic signed [VALUE_WIDTH-1:0] out_interp_value,
  output logic [1:0]                    out_status
);
  import bgi_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int VW = VALUE_WIDTH;
  localparam int NW = VW + 2 * CW + 4;
  localparam int PW = 2 * CW + 2;
  localparam int SW = VW + 3;
  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

  ctl_t                 ctl_p, ctl_m, ctl_d;
  logic signed [CW:0]   dxh, dxl, dyh, dyl, wx, wy, span, off;
  logic signed [VW:0]   dval;
  logic signed [VW-1:0] vll_p, vlh_p, vhl_p, vhh_p, vll_m, vll_d;
  logic signed [NW-1:0] num_m;
  logic signed [PW-1:0] den_m;
  logic [VW:0]          quo_d;
  logic                 neg_d, ovf_d;

  logic signed [VW+1:0] qs;
  logic signed [SW-1:0] addend, sum;
  logic [3:0]           top_bits;
  logic                 fits;
  logic signed [VW-1:0] value_nxt, value_r;
  logic                 valid_r;
  status_t              status_r;

  assign busy = 1'b0;

  bgi_prep #(.CW(CW), .VW(VW)) u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (start & !busy),
    .point_count (in_point_count),
    .lo_x        (in_lo_x),
    .lo_y        (in_lo_y),
    .hi_x        (in_hi_x),
    .hi_y        (in_hi_y),
    .val_lo_lo   (in_val_lo_lo),
    .val_lo_hi   (in_val_lo_hi),
    .val_hi_lo   (in_val_hi_lo),
    .val_hi_hi   (in_val_hi_hi),
    .req_x       (in_req_x),
    .req_y       (in_req_y),
    .ctl_o       (ctl_p),
    .dxh_o       (dxh),
    .dxl_o       (dxl),
    .dyh_o       (dyh),
    .dyl_o       (dyl),
    .wx_o        (wx),
    .wy_o        (wy),
    .span_o      (span),
    .off_o       (off),
    .dval_o      (dval),
    .vll_o       (vll_p),
    .vlh_o       (vlh_p),
    .vhl_o       (vhl_p),
    .vhh_o       (vhh_p)
  );

  bgi_mult #(.CW(CW), .VW(VW)) u_mult (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl_p),
    .dxh_i  (dxh),
    .dxl_i  (dxl),
    .dyh_i  (dyh),
    .dyl_i  (dyl),
    .wx_i   (wx),
    .wy_i   (wy),
    .span_i (span),
    .off_i  (off),
    .dval_i (dval),
    .vll_i  (vll_p),
    .vlh_i  (vlh_p),
    .vhl_i  (vhl_p),
    .vhh_i  (vhh_p),
    .ctl_o  (ctl_m),
    .num_o  (num_m),
    .den_o  (den_m),
    .vll_o  (vll_m)
  );

  bgi_div #(.CW(CW), .VW(VW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl_m),
    .num_i (num_m),
    .den_i (den_m),
    .vll_i (vll_m),
    .ctl_o (ctl_d),
    .quo_o (quo_d),
    .neg_o (neg_d),
    .ovf_o (ovf_d),
    .vll_o (vll_d)
  );

  // For two nodes the quotient is added to the first value before the
  // result is saturated.
  always_comb begin
    qs = $signed({1'b0, quo_d});
    if (neg_d) begin
      qs = -qs;
    end
    addend   = (ctl_d.mode == MODE_LINE) ? SW'(vll_d) : '0;
    sum      = SW'(qs) + addend;
    top_bits = sum[SW-1:VW-1];
    fits     = (&top_bits) | ~(|top_bits);
    if (ctl_d.status != ST_OK) begin
      value_nxt = '0;
    end else if (ctl_d.mode == MODE_PASS) begin
      value_nxt = vll_d;
    end else if (ovf_d) begin
      value_nxt = neg_d ? VAL_MIN : VAL_MAX;
    end else if (fits) begin
      value_nxt = $signed(sum[VW-1:0]);
    end else begin
      value_nxt = sum[SW-1] ? VAL_MIN : VAL_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_d.valid;
    end
  end

  always_ff @(posedge clk) begin
    value_r  <= value_nxt;
    status_r <= ctl_d.status;
  end

  assign out_valid        = valid_r;
  assign out_interp_value = value_r;
  assign out_status       = status_r;

endmodule
